/* rtl/tgc_pkg.sv */
// Shared types, constants and register codes of the touch gesture classifier.
// No dependencies; every other file in rtl imports this package.
package tgc_pkg;

	// Tank geometry in landscape pixels.
	localparam int TANK_W = 1280;
	localparam int TANK_H = 720;

	// Field widths.
	localparam int X_W     = $clog2(TANK_W);
	localparam int Y_W     = $clog2(TANK_H);
	localparam int RAW_X_W = 10;
	localparam int RAW_Y_W = 11;
	localparam int T_W     = 48;
	localparam int US_W    = 22;
	localparam int DIST_W  = 16;
	localparam int LIM_W   = 10;
	localparam int BIAS_W  = 7;

	// Signed width wide enough for any mapped coordinate before clamping.
	localparam int MAP_W = 13;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_DATA_W  = ((RAW_X_W + RAW_Y_W + T_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * X_W + 2 * Y_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = US_W;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INVERTED,
		CFG_BIAS_Y,
		CFG_TAP_MAX_US,
		CFG_TAP_MAX_DIST_SQ,
		CFG_HOLD_MIN_US,
		CFG_HOLD_MAX_DY,
		CFG_FEED_TOP_LIMIT,
		CFG_FEED_MIN_DY
	} cfg_idx_t;

	// Release classes.
	typedef enum logic [1:0] {
		GEST_NONE,
		GEST_TAP,
		GEST_FEED,
		GEST_OTHER
	} gesture_t;

	typedef struct packed {
		logic                     inverted;
		logic signed [BIAS_W-1:0] bias_y;
		logic [US_W-1:0]          tap_max_us;
		logic [DIST_W-1:0]        tap_max_dist_sq;
		logic [US_W-1:0]          hold_min_us;
		logic [LIM_W-1:0]         hold_max_dy;
		logic [LIM_W-1:0]         feed_top_limit;
		logic [LIM_W-1:0]         feed_min_dy;
	} cfg_t;

	localparam cfg_t CFG_DEFAULT = '{
		inverted:        1'b0,
		bias_y:          BIAS_W'(10),
		tap_max_us:      US_W'(350000),
		tap_max_dist_sq: DIST_W'(24 * 24),
		hold_min_us:     US_W'(300000),
		hold_max_dy:     LIM_W'(30),
		feed_top_limit:  LIM_W'(60),
		feed_min_dy:     LIM_W'(40)
	};

	// One touch frame as held in the input register.
	typedef struct packed {
		logic               touched;
		logic [RAW_X_W-1:0] raw_x;
		logic [RAW_Y_W-1:0] raw_y;
		logic [T_W-1:0]     now_us;
	} frame_t;

	// One result item as held in the output register.
	typedef struct packed {
		logic [X_W-1:0] cur_x;
		logic [Y_W-1:0] cur_y;
		logic           drag;
		logic           hold;
		gesture_t       gesture;
		logic [X_W-1:0] gesture_x;
		logic [Y_W-1:0] gesture_y;
	} result_t;

endpackage

/* rtl/tgc_map.sv */
// Maps a portrait panel point into landscape tank space with bias and clamping.
// Depends on tgc_pkg.
module tgc_map
	import tgc_pkg::*;
(
	input  logic                     inverted,
	input  logic signed [BIAS_W-1:0] bias_y,
	input  logic [RAW_X_W-1:0]       raw_x,
	input  logic [RAW_Y_W-1:0]       raw_y,
	output logic [X_W-1:0]           map_x,
	output logic [Y_W-1:0]           map_y
);

	localparam logic signed [MAP_W-1:0] XMAX = MAP_W'(TANK_W - 1);
	localparam logic signed [MAP_W-1:0] YMAX = MAP_W'(TANK_H - 1);

	logic signed [MAP_W-1:0] rx_s;
	logic signed [MAP_W-1:0] ry_s;
	logic signed [MAP_W-1:0] bias_s;
	logic signed [MAP_W-1:0] mx;
	logic signed [MAP_W-1:0] my;

	// Rotate by a quarter turn, mirrored in both axes when the screen is flipped.
	always_comb begin
		rx_s   = signed'({{(MAP_W-RAW_X_W){1'b0}}, raw_x});
		ry_s   = signed'({{(MAP_W-RAW_Y_W){1'b0}}, raw_y});
		bias_s = {{(MAP_W-BIAS_W){bias_y[BIAS_W-1]}}, bias_y};
		mx     = inverted ? ry_s : (XMAX - ry_s);
		my     = (inverted ? (YMAX - rx_s) : rx_s) - bias_s;
	end

	// Saturate both coordinates to the tank.
	always_comb begin
		if (mx < 0) begin
			map_x = '0;
		end else if (mx > XMAX) begin
			map_x = XMAX[X_W-1:0];
		end else begin
			map_x = mx[X_W-1:0];
		end
		if (my < 0) begin
			map_y = '0;
		end else if (my > YMAX) begin
			map_y = YMAX[Y_W-1:0];
		end else begin
			map_y = my[Y_W-1:0];
		end
	end

endmodule

/* rtl/tgc_track.sv */
// Stroke state (press point, press time, last point) and per-frame classification.
// Depends on tgc_pkg; fed by tgc_map with the mapped point of the current frame.
module tgc_track
	import tgc_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  cfg_t           cfg,
	input  logic           touched,
	input  logic [T_W-1:0] now_us,
	input  logic [X_W-1:0] map_x,
	input  logic [Y_W-1:0] map_y,
	output result_t        result
);

	localparam int DX_W = X_W + 1;
	localparam int DY_W = Y_W + 1;
	localparam int SQ_W = 2 * DX_W + 1;

	logic           was_down_q;
	logic [T_W-1:0] press_time_q;
	logic [X_W-1:0] press_x_q;
	logic [Y_W-1:0] press_y_q;
	logic [X_W-1:0] last_x_q;
	logic [Y_W-1:0] last_y_q;

	logic [T_W-1:0]         p_time;
	logic [Y_W-1:0]         p_y;
	logic [T_W-1:0]         dur;
	logic signed [DY_W-1:0] hold_dy;
	logic [DY_W-1:0]        hold_dy_abs;
	logic                   hold_ok;
	logic signed [DX_W-1:0] rel_dx;
	logic signed [DY_W-1:0] rel_dy;
	logic [SQ_W-1:0]        dx_sq;
	logic [SQ_W-1:0]        dy_sq;
	logic [SQ_W-1:0]        dist_sq;
	logic                   is_tap;
	logic                   is_feed;

	// A press frame measures against its own time and point.
	always_comb begin
		p_time = was_down_q ? press_time_q : now_us;
		p_y    = was_down_q ? press_y_q : map_y;
		dur    = now_us - p_time;
	end

	// Hold: long enough and little vertical drift from the press.
	always_comb begin
		hold_dy     = signed'({1'b0, map_y}) - signed'({1'b0, p_y});
		hold_dy_abs = hold_dy[DY_W-1] ? DY_W'(-hold_dy) : DY_W'(hold_dy);
		hold_ok     = (dur > {{(T_W-US_W){1'b0}}, cfg.hold_min_us}) &&
		              (hold_dy_abs < {1'b0, cfg.hold_max_dy});
	end

	// Release: displacement of the last point from the press point.
	always_comb begin
		rel_dx  = signed'({1'b0, last_x_q}) - signed'({1'b0, press_x_q});
		rel_dy  = signed'({1'b0, last_y_q}) - signed'({1'b0, press_y_q});
		dx_sq   = unsigned'(SQ_W'(rel_dx) * SQ_W'(rel_dx));
		dy_sq   = unsigned'(SQ_W'(rel_dy) * SQ_W'(rel_dy));
		dist_sq = dx_sq + dy_sq;
		is_tap  = (dur < {{(T_W-US_W){1'b0}}, cfg.tap_max_us}) &&
		          (dist_sq < {{(SQ_W-DIST_W){1'b0}}, cfg.tap_max_dist_sq});
		is_feed = (press_y_q < cfg.feed_top_limit) &&
		          !rel_dy[DY_W-1] &&
		          (unsigned'(rel_dy) >= {1'b0, cfg.feed_min_dy});
	end

	// Result of the frame.
	always_comb begin
		result.cur_x     = touched ? map_x : last_x_q;
		result.cur_y     = touched ? map_y : last_y_q;
		result.drag      = touched;
		result.hold      = touched && hold_ok;
		result.gesture   = GEST_NONE;
		result.gesture_x = '0;
		result.gesture_y = '0;
		if (!touched && was_down_q) begin
			priority if (is_tap) begin
				result.gesture   = GEST_TAP;
				result.gesture_x = press_x_q;
				result.gesture_y = press_y_q;
			end else if (is_feed) begin
				result.gesture   = GEST_FEED;
				result.gesture_x = last_x_q;
				result.gesture_y = last_y_q;
			end else begin
				result.gesture   = GEST_OTHER;
			end
		end
	end

	// Stroke state advances once per frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_down_q   <= 1'b0;
			press_time_q <= '0;
			press_x_q    <= '0;
			press_y_q    <= '0;
			last_x_q     <= '0;
			last_y_q     <= '0;
		end else if (step) begin
			was_down_q <= touched;
			if (touched) begin
				if (!was_down_q) begin
					press_time_q <= now_us;
					press_x_q    <= map_x;
					press_y_q    <= map_y;
				end
				last_x_q <= map_x;
				last_y_q <= map_y;
			end
		end
	end

endmodule

/* rtl/touch_gesture_classifier_core.sv */
// Top level of the touch gesture classifier: stream ports, configuration
// registers, input and result registers. Depends on tgc_pkg, tgc_map, tgc_track.
//
// Each input item is one touch frame and yields exactly one result item. An
// item is registered on entry in the input register and its result is then
// registered in the result register once that is empty or being emptied;
// when the output side is ready, one item per cycle is sustained. The logic
// between the two registers holds the point mapping and clamp, a 48-bit duration
// subtract with its compares, and a 12x12 and an 11x11 square. The input
// keeps accepting while a result waits, as long as the input register can
// move on. Configuration writes are always ready and take effect at once; they
// are meant to be made only while no item is in flight.
module touch_gesture_classifier_core
	import tgc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Touch frame input.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // raw_x, raw_y, now_us, zero pad
	input  logic                  s_tuser,  // touched
	// Result output.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // cur_x, cur_y, gesture_x, gesture_y, zero pad
	output logic [OUT_USER_W-1:0] m_tuser,  // drag, hold, gesture
	// Configuration writes.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	logic    valid_s1;
	frame_t  frame_s1;
	logic    valid_s2;
	result_t result_s2;
	logic    advance;
	logic    in_take;
	logic [X_W-1:0] map_x;
	logic [Y_W-1:0] map_y;
	result_t        result;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_DEFAULT;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_INVERTED:        cfg_q.inverted        <= cfg_data[0];
				CFG_BIAS_Y:          cfg_q.bias_y          <= cfg_data[BIAS_W-1:0];
				CFG_TAP_MAX_US:      cfg_q.tap_max_us      <= cfg_data[US_W-1:0];
				CFG_TAP_MAX_DIST_SQ: cfg_q.tap_max_dist_sq <= cfg_data[DIST_W-1:0];
				CFG_HOLD_MIN_US:     cfg_q.hold_min_us     <= cfg_data[US_W-1:0];
				CFG_HOLD_MAX_DY:     cfg_q.hold_max_dy     <= cfg_data[LIM_W-1:0];
				CFG_FEED_TOP_LIMIT:  cfg_q.feed_top_limit  <= cfg_data[LIM_W-1:0];
				CFG_FEED_MIN_DY:     cfg_q.feed_min_dy     <= cfg_data[LIM_W-1:0];
			endcase
		end
	end

	// Flow control: the input register moves on whenever the result register
	// is empty or being emptied.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_take  = s_tvalid && s_tready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			frame_s1.touched <= s_tuser;
			frame_s1.raw_x   <= s_tdata[RAW_X_W-1:0];
			frame_s1.raw_y   <= s_tdata[RAW_X_W +: RAW_Y_W];
			frame_s1.now_us  <= s_tdata[RAW_X_W + RAW_Y_W +: T_W];
		end
	end

	tgc_map u_map (
		.inverted (cfg_q.inverted),
		.bias_y   (cfg_q.bias_y),
		.raw_x    (frame_s1.raw_x),
		.raw_y    (frame_s1.raw_y),
		.map_x    (map_x),
		.map_y    (map_y)
	);

	tgc_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.cfg     (cfg_q),
		.touched (frame_s1.touched),
		.now_us  (frame_s1.now_us),
		.map_x   (map_x),
		.map_y   (map_y),
		.result  (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	// Output packing.
	assign m_tvalid = valid_s2;
	assign m_tdata  = OUT_DATA_W'({result_s2.gesture_y, result_s2.gesture_x,
	                               result_s2.cur_y, result_s2.cur_x});
	assign m_tuser  = {result_s2.gesture, result_s2.hold, result_s2.drag};

endmodule

/* rtl/tgc_checker.sv */
// Port-level checks of the touch gesture classifier, bound to the top level.
// Depends on tgc_pkg and touch_gesture_classifier_core.
module tgc_checker
	import tgc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser
);

	logic     drag;
	logic     hold;
	gesture_t gesture;

	assign drag    = m_tuser[0];
	assign hold    = m_tuser[1];
	assign gesture = gesture_t'(m_tuser[3:2]);

	// A stalled result item keeps its payload.
	a_stall_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	// Hold is only reported on a touched frame.
	a_hold_needs_drag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && hold |-> drag)
		else $error("hold reported on an untouched frame");

	// A touched frame never carries a release class.
	a_drag_no_gesture: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && drag |-> gesture == GEST_NONE)
		else $error("release class on a touched frame");

	// Without a tap or feed the gesture point is zero.
	a_gesture_point: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (gesture == GEST_NONE || gesture == GEST_OTHER) |->
			m_tdata[2*X_W+Y_W-1:X_W+Y_W] == '0 &&
			m_tdata[2*X_W+2*Y_W-1:2*X_W+Y_W] == '0)
		else $error("gesture point set without tap or feed");

endmodule

bind touch_gesture_classifier_core tgc_checker u_tgc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* tb/tgc_frame_checker.sv */
// Checker for the touch gesture classifier: watches the frame, result and register write
// channels, predicts each result from its own copy of the state and compares it field by field.
// Depends on tgc_pkg for widths, register codes, gesture codes and the reset configuration.
`timescale 1ns / 100ps

module tgc_frame_checker
	import tgc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // raw_x, raw_y, now_us, zero pad
	input  logic                  s_tuser,  // touched
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,  // cur_x, cur_y, gesture_x, gesture_y, zero pad
	input  logic [OUT_USER_W-1:0] m_tuser,  // drag, hold, gesture
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending
);

	// Register copy and stroke state of the predictor.
	cfg_t           cfg;
	logic           was_down;
	logic [T_W-1:0] press_time;
	logic [X_W-1:0] press_x, last_x;
	logic [Y_W-1:0] press_y, last_y;

	// Results predicted but not yet seen on the output, oldest first.
	result_t expected_results[$];

	// Prints one line per mismatch (the first few only) and counts every one.
	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 40)
			$display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic int clip(input int v, input int hi);
		return (v < 0) ? 0 : ((v > hi) ? hi : v);
	endfunction

	// Advances the stroke state by one frame and returns the result it should produce.
	function automatic result_t follow_frame(input logic touched, input logic [RAW_X_W-1:0] rx,
			input logic [RAW_Y_W-1:0] ry, input logic [T_W-1:0] ts);
		result_t        r;
		logic [T_W-1:0] span;
		int             mx, my, dx, dy;
		r = '0;
		r.drag = touched;
		r.gesture = GEST_NONE;
		if (touched) begin
			// Map into landscape space, remove the finger bias and clamp to the tank.
			mx = cfg.inverted ? int'(ry) : TANK_W - 1 - int'(ry);
			my = (cfg.inverted ? TANK_H - 1 - int'(rx) : int'(rx)) - int'($signed(cfg.bias_y));
			last_x = X_W'(clip(mx, TANK_W - 1));
			last_y = Y_W'(clip(my, TANK_H - 1));
			if (!was_down) begin
				press_time = ts;
				press_x = last_x;
				press_y = last_y;
			end
			span = ts - press_time;
			dy = int'(last_y) - int'(press_y);
			if (dy < 0)
				dy = -dy;
			r.hold = (span > T_W'(cfg.hold_min_us)) && (dy < int'(cfg.hold_max_dy));
		end else if (was_down) begin
			// Release: tap wins over feed, anything else is a plain release.
			span = ts - press_time;
			dx = int'(last_x) - int'(press_x);
			dy = int'(last_y) - int'(press_y);
			if (span < T_W'(cfg.tap_max_us) && dx * dx + dy * dy < int'(cfg.tap_max_dist_sq)) begin
				r.gesture = GEST_TAP;
				r.gesture_x = press_x;
				r.gesture_y = press_y;
			end else if (int'(press_y) < int'(cfg.feed_top_limit) &&
					dy >= int'(cfg.feed_min_dy)) begin
				r.gesture = GEST_FEED;
				r.gesture_x = last_x;
				r.gesture_y = last_y;
			end else begin
				r.gesture = GEST_OTHER;
			end
		end
		r.cur_x = last_x;
		r.cur_y = last_y;
		was_down = touched;
		return r;
	endfunction

	// Results are compared before new frames are predicted in the same cycle.
	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			cfg = CFG_DEFAULT;
			was_down = 1'b0;
			press_time = '0;
			press_x = '0;
			press_y = '0;
			last_x = '0;
			last_y = '0;
			expected_results.delete();
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.cur_x = m_tdata[X_W-1:0];
				got.cur_y = m_tdata[X_W +: Y_W];
				got.gesture_x = m_tdata[X_W + Y_W +: X_W];
				got.gesture_y = m_tdata[2 * X_W + Y_W +: Y_W];
				got.drag = m_tuser[0];
				got.hold = m_tuser[1];
				got.gesture = gesture_t'(m_tuser[3:2]);
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result item", int'(got.cur_x), -1);
				end else begin
					want = expected_results.pop_front();
					if (got.cur_x !== want.cur_x)
						report_mismatch("cur_x", int'(got.cur_x), int'(want.cur_x));
					if (got.cur_y !== want.cur_y)
						report_mismatch("cur_y", int'(got.cur_y), int'(want.cur_y));
					if (got.drag !== want.drag)
						report_mismatch("drag", int'(got.drag), int'(want.drag));
					if (got.hold !== want.hold)
						report_mismatch("hold", int'(got.hold), int'(want.hold));
					if (got.gesture !== want.gesture)
						report_mismatch("gesture", int'(got.gesture), int'(want.gesture));
					if (got.gesture_x !== want.gesture_x)
						report_mismatch("gesture_x", int'(got.gesture_x),
							int'(want.gesture_x));
					if (got.gesture_y !== want.gesture_y)
						report_mismatch("gesture_y", int'(got.gesture_y),
							int'(want.gesture_y));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_INVERTED:        cfg.inverted = cfg_data[0];
					CFG_BIAS_Y:          cfg.bias_y = cfg_data[BIAS_W-1:0];
					CFG_TAP_MAX_US:      cfg.tap_max_us = cfg_data[US_W-1:0];
					CFG_TAP_MAX_DIST_SQ: cfg.tap_max_dist_sq = cfg_data[DIST_W-1:0];
					CFG_HOLD_MIN_US:     cfg.hold_min_us = cfg_data[US_W-1:0];
					CFG_HOLD_MAX_DY:     cfg.hold_max_dy = cfg_data[LIM_W-1:0];
					CFG_FEED_TOP_LIMIT:  cfg.feed_top_limit = cfg_data[LIM_W-1:0];
					CFG_FEED_MIN_DY:     cfg.feed_min_dy = cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(follow_frame(s_tuser, s_tdata[RAW_X_W-1:0],
					s_tdata[RAW_X_W +: RAW_Y_W], s_tdata[RAW_X_W + RAW_Y_W +: T_W]));
			pending <= expected_results.size();
		end
	end

endmodule

/* tb/tb.sv */
// Testbench top for the touch gesture classifier: clock, reset, register writes, touch
// strokes and random frames, random output stalls, a watchdog and the verdict.
// Depends on tgc_pkg, touch_gesture_classifier_core and tgc_frame_checker.
`timescale 1ns / 100ps

module tb;
	import tgc_pkg::*;

	localparam int STALL_LIMIT = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // raw_x, raw_y, now_us, zero pad
	logic                  s_tuser = 1'b0; // touched
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // cur_x, cur_y, gesture_x, gesture_y, zero pad
	logic [OUT_USER_W-1:0] m_tuser;        // drag, hold, gesture
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    mismatches;
	int                    pending;

	// Stimulus bookkeeping: mapping settings in force, frame clock and item count.
	bit             steady = 1'b0;
	bit             inv_now = 1'b0;
	int             bias_now = 10;
	logic [T_W-1:0] clock_us = '0;
	int             sent = 0;
	int             idle_cycles = 0;

	always #4 clk = ~clk;

	touch_gesture_classifier_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tgc_frame_checker u_frame_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// The result side stalls at random with a chance of about 14 in a hundred, except in steady stretches.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 14);
	end

	// Watchdog on cycles in which no channel moves an item.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("touch_gesture_classifier_core verification failed");
				$finish;
			end
		end
	end

	// Offers one frame, with a random gap first outside steady stretches, and returns at the cycle it is taken.
	task automatic send_frame(input logic touched, input logic [RAW_X_W-1:0] rx,
			input logic [RAW_Y_W-1:0] ry, input logic [T_W-1:0] ts);
		if (!steady) begin
			while ($urandom_range(0, 99) < 14) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= touched;
		s_tdata <= IN_DATA_W'({ts, ry, rx});
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Touches a tank point dt microseconds after the previous frame; raw values may
	// fall beyond the panel, which exercises the clamp.
	task automatic touch_at(input int tx, input int ty, input int dt);
		int rx, ry;
		clock_us = clock_us + T_W'(dt);
		ry = inv_now ? tx : TANK_W - 1 - tx;
		rx = inv_now ? TANK_H - 1 - (ty + bias_now) : ty + bias_now;
		rx = (rx < 0) ? 0 : ((rx > (1 << RAW_X_W) - 1) ? (1 << RAW_X_W) - 1 : rx);
		ry = (ry < 0) ? 0 : ((ry > (1 << RAW_Y_W) - 1) ? (1 << RAW_Y_W) - 1 : ry);
		send_frame(1'b1, RAW_X_W'(rx), RAW_Y_W'(ry), clock_us);
	endtask

	// Untouched frame; the point fields carry random content the block must ignore.
	task automatic lift(input int dt);
		clock_us = clock_us + T_W'(dt);
		send_frame(1'b0, RAW_X_W'($urandom), RAW_Y_W'($urandom), clock_us);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(input bit inv, input int bias, input int tap_us, input int tap_d2,
			input int hold_us, input int hold_dy, input int top, input int min_dy);
		write_reg(CFG_INVERTED, CFG_DATA_W'(inv));
		write_reg(CFG_BIAS_Y, CFG_DATA_W'(bias));
		write_reg(CFG_TAP_MAX_US, CFG_DATA_W'(tap_us));
		write_reg(CFG_TAP_MAX_DIST_SQ, CFG_DATA_W'(tap_d2));
		write_reg(CFG_HOLD_MIN_US, CFG_DATA_W'(hold_us));
		write_reg(CFG_HOLD_MAX_DY, CFG_DATA_W'(hold_dy));
		write_reg(CFG_FEED_TOP_LIMIT, CFG_DATA_W'(top));
		write_reg(CFG_FEED_MIN_DY, CFG_DATA_W'(min_dy));
		cfg_valid <= 1'b0;
		inv_now = inv;
		bias_now = bias;
	endtask

	// Stops offering frames and waits for every result, then for the pipeline depth.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One stroke of a random kind, or a single frame of noise.
	task automatic run_stroke();
		int kind, n, tx, ty, sx, sy, jit, dlo, dhi, j, k;
		kind = $urandom_range(0, 9);
		tx = $urandom_range(0, TANK_W - 1);
		ty = $urandom_range(0, TANK_H - 1);
		sx = 0;
		sy = 0;
		jit = 2;
		dlo = 5000;
		dhi = 40000;
		n = $urandom_range(1, 4);
		case (kind)
			0, 1: ;
			2, 3: begin
				// Downward drag from near the top edge.
				ty = $urandom_range(0, 80);
				sy = $urandom_range(5, 25);
				n = $urandom_range(2, 8);
				dlo = 10000;
				dhi = 60000;
			end
			4, 5: begin
				n = $urandom_range(4, 20);
				jit = 4;
				dlo = 20000;
				dhi = 60000;
			end
			6: begin
				sx = $urandom_range(0, 80);
				sx -= 40;
				sy = $urandom_range(0, 80);
				sy -= 40;
				n = $urandom_range(2, 10);
			end
			7: begin
				// Slow frames, spaced 100000 to 3000000 microseconds apart.
				dlo = 100000;
				dhi = 3000000;
			end
			default: begin
				// Noise: any field value, sometimes a timestamp jump that wraps or goes back.
				if ($urandom_range(0, 3) == 0)
					clock_us = T_W'({$urandom, $urandom});
				else
					clock_us = clock_us + T_W'($urandom_range(0, 500000));
				send_frame(1'($urandom), RAW_X_W'($urandom), RAW_Y_W'($urandom), clock_us);
				return;
			end
		endcase
		for (k = 0; k < n; k++) begin
			j = $urandom_range(0, 2 * jit);
			touch_at(tx + k * sx + j - jit, ty + k * sy + j - jit, $urandom_range(dlo, dhi));
		end
		// Now and then the stroke simply runs on into the next one.
		if ($urandom_range(0, 7) != 0)
			lift($urandom_range(dlo, dhi));
	endtask

	initial begin
		int target;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames under the reset configuration.
		lift(1000);
		touch_at(640, 300, 10000);
		lift(100000);
		touch_at(200, 10, 50000);
		touch_at(200, 50, 200000);
		touch_at(200, 90, 200000);
		lift(20000);
		touch_at(900, 400, 30000);
		touch_at(902, 405, 400000);
		lift(20000);
		send_frame(1'b1, '0, '0, clock_us);
		send_frame(1'b1, '1, '1, clock_us + T_W'(1000));
		lift(2000);
		clock_us = {T_W{1'b1}} - T_W'(16);
		touch_at(100, 100, 5);
		touch_at(101, 100, 100);
		lift(100);
		touch_at(300, 300, 10);
		lift(-5000);
		drain();

		// Random phases, each under its own register setting.
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: program_regs(1'b1, -64, 200000, 900, 150000, 50, 120, 20);
				1: program_regs(1'b0, 63, (1 << US_W) - 1, (1 << DIST_W) - 1, (1 << US_W) - 1,
					(1 << LIM_W) - 1, (1 << LIM_W) - 1, (1 << LIM_W) - 1);
				2: program_regs(1'b1, 0, 0, 0, 0, 0, 0, 0);
				3: program_regs(1'($urandom), int'($urandom_range(0, 127)) - 64,
					$urandom_range(0, 600000), $urandom_range(0, 4000), $urandom_range(0, 600000),
					$urandom_range(0, 80), $urandom_range(0, 200), $urandom_range(0, 100));
				default: program_regs(CFG_DEFAULT.inverted, int'($signed(CFG_DEFAULT.bias_y)),
					int'(CFG_DEFAULT.tap_max_us), int'(CFG_DEFAULT.tap_max_dist_sq),
					int'(CFG_DEFAULT.hold_min_us), int'(CFG_DEFAULT.hold_max_dy),
					int'(CFG_DEFAULT.feed_top_limit), int'(CFG_DEFAULT.feed_min_dy));
			endcase
			steady = (ph == 4);
			target = sent + 100;
			while (sent < target - 50)
				run_stroke();
			// Hold off mid-phase until every outstanding result has come back.
			drain();
			while (sent < target)
				run_stroke();
			drain();
		end

		if (mismatches == 0)
			$display("touch_gesture_classifier_core verification clean");
		else
			$display("touch_gesture_classifier_core verification failed");
		$finish;
	end

endmodule

/* filelist.f */
rtl/tgc_pkg.sv
rtl/tgc_map.sv
rtl/tgc_track.sv
rtl/touch_gesture_classifier_core.sv
rtl/tgc_checker.sv
tb/tgc_frame_checker.sv
tb/tb.sv
